### rtl/uvs_pkg.sv
// Shared types, constants and helpers for the UTF-8 validate/sanitize block.
package uvs_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int SUM_W       = COUNT_WIDTH + 3;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    typedef logic [COUNT_WIDTH-1:0] cnt_t;

    localparam cnt_t CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Work for the back end: replacements first, then pass bytes, then an optional report.
    typedef struct packed {
        logic [2:0]      nrepl;
        logic [2:0]      npass;
        logic [3:0][7:0] bytes;
        logic            report;
        logic            text_valid;
        cnt_t            base_cnt;
        cnt_t            final_cnt;
    } job_t;

    function automatic cnt_t sat_add(input cnt_t a, input logic [2:0] n);
        logic [SUM_W-1:0] sum;
        begin
            sum = SUM_W'(a) + SUM_W'(n);
            if (sum > SUM_W'(CNT_MAX))
            begin
                sat_add = CNT_MAX;
            end
            else
            begin
                sat_add = sum[COUNT_WIDTH-1:0];
            end
        end
    endfunction

endpackage

### rtl/uvs_front.sv
// Front end: takes input bytes, tracks the open sequence and issues jobs.
module uvs_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         in_end,
    input  logic [7:0]   in_byte,
    input  logic         q_full,
    output logic         q_push,
    output uvs_pkg::job_t q_job
);

    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] L2_LO     = 8'hC2;
    localparam logic [7:0] L2_HI     = 8'hDF;
    localparam logic [7:0] L3_LO     = 8'hE0;
    localparam logic [7:0] L3_HI     = 8'hEF;
    localparam logic [7:0] L4_LO     = 8'hF0;
    localparam logic [7:0] L4_HI     = 8'hF4;
    localparam logic [7:0] C_LO      = 8'h80;
    localparam logic [7:0] C_HI      = 8'hBF;
    localparam logic [7:0] E0_LO     = 8'hA0;
    localparam logic [7:0] ED_HI     = 8'h9F;
    localparam logic [7:0] F0_LO     = 8'h90;
    localparam logic [7:0] F4_HI     = 8'h8F;
    localparam logic [7:0] LEAD_E0   = 8'hE0;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] LEAD_F0   = 8'hF0;
    localparam logic [7:0] LEAD_F4   = 8'hF4;

    logic [7:0]      lead_reg, lead_next;
    logic [7:0]      cont_reg [2];
    logic [7:0]      cont_next [2];
    logic [1:0]      held_reg, held_next;
    logic [2:0]      len_reg, len_next;
    uvs_pkg::cnt_t   cnt_reg, cnt_next;
    logic            allv_reg, allv_next;

    logic            accept;
    logic            cont_ok;
    logic [7:0]      lo, hi;
    logic            do_lead;
    logic [2:0]      nflush;
    logic            lead_bad;
    logic [2:0]      nrepl;
    logic [2:0]      npass;
    logic [3:0][7:0] bytes;
    logic            report;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        lo = C_LO;
        hi = C_HI;
        if (held_reg == 2'd0)
        begin
            if (lead_reg == LEAD_E0)
            begin
                lo = E0_LO;
            end
            else if (lead_reg == LEAD_ED)
            begin
                hi = ED_HI;
            end
            else if (lead_reg == LEAD_F0)
            begin
                lo = F0_LO;
            end
            else if (lead_reg == LEAD_F4)
            begin
                hi = F4_HI;
            end
        end
        cont_ok = (in_byte >= lo) && (in_byte <= hi);
    end

    always_comb
    begin
        lead_next    = lead_reg;
        cont_next[0] = cont_reg[0];
        cont_next[1] = cont_reg[1];
        held_next    = held_reg;
        len_next     = len_reg;
        do_lead      = 1'b0;
        nflush       = 3'd0;
        lead_bad     = 1'b0;
        npass        = 3'd0;
        report       = 1'b0;
        bytes[0]     = lead_reg;
        bytes[1]     = (held_reg >= 2'd1) ? cont_reg[0] : in_byte;
        bytes[2]     = (held_reg >= 2'd2) ? cont_reg[1] : in_byte;
        bytes[3]     = in_byte;

        if (in_end)
        begin
            report = 1'b1;
            if (len_reg != 3'd0)
            begin
                nflush = 3'd1 + 3'(held_reg);
            end
            lead_next = 8'h00;
            held_next = 2'd0;
            len_next  = 3'd0;
        end
        else if (len_reg == 3'd0)
        begin
            do_lead = 1'b1;
        end
        else if (cont_ok)
        begin
            if ((3'(held_reg) + 3'd2) >= len_reg)
            begin
                npass     = 3'(held_reg) + 3'd2;
                lead_next = 8'h00;
                held_next = 2'd0;
                len_next  = 3'd0;
            end
            else
            begin
                cont_next[held_reg[0]] = in_byte;
                held_next              = held_reg + 2'd1;
            end
        end
        else
        begin
            nflush    = 3'd1 + 3'(held_reg);
            lead_next = 8'h00;
            held_next = 2'd0;
            len_next  = 3'd0;
            do_lead   = 1'b1;
        end

        if (do_lead)
        begin
            if (in_byte <= ASCII_MAX)
            begin
                npass    = 3'd1;
                bytes[0] = in_byte;
            end
            else if (in_byte >= L2_LO && in_byte <= L2_HI)
            begin
                len_next  = 3'd2;
                lead_next = in_byte;
                held_next = 2'd0;
            end
            else if (in_byte >= L3_LO && in_byte <= L3_HI)
            begin
                len_next  = 3'd3;
                lead_next = in_byte;
                held_next = 2'd0;
            end
            else if (in_byte >= L4_LO && in_byte <= L4_HI)
            begin
                len_next  = 3'd4;
                lead_next = in_byte;
                held_next = 2'd0;
            end
            else
            begin
                lead_bad = 1'b1;
            end
        end

        nrepl     = nflush + 3'(lead_bad);
        cnt_next  = uvs_pkg::sat_add(cnt_reg, nrepl);
        allv_next = allv_reg && (nrepl == 3'd0);

        q_job.nrepl      = nrepl;
        q_job.npass      = npass;
        q_job.bytes      = bytes;
        q_job.report     = report;
        q_job.text_valid = allv_next;
        q_job.base_cnt   = cnt_reg;
        q_job.final_cnt  = cnt_next;

        if (in_end)
        begin
            cnt_next  = '0;
            allv_next = 1'b1;
        end
    end

    assign q_push = accept && ((nrepl != 3'd0) || (npass != 3'd0) || report);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= 8'h00;
            held_reg <= 2'd0;
            len_reg  <= 3'd0;
            cnt_reg  <= '0;
            allv_reg <= 1'b1;
        end
        else if (accept)
        begin
            lead_reg <= lead_next;
            held_reg <= held_next;
            len_reg  <= len_next;
            cnt_reg  <= cnt_next;
            allv_reg <= allv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cont_reg[0] <= cont_next[0];
            cont_reg[1] <= cont_next[1];
        end
    end

    a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_end) |=> (cnt_reg >= $past(cnt_reg)))
        else $error("replacement counter decreased within a text");

    a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg == 3'd0) |-> (held_reg == 2'd0))
        else $error("continuation bytes held with no open sequence");

endmodule

### rtl/uvs_queue.sv
// Short job queue between front and back ends.
module uvs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  uvs_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output uvs_pkg::job_t head_job
);

    uvs_pkg::job_t                 mem [uvs_pkg::Q_DEPTH];
    logic [uvs_pkg::Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [uvs_pkg::Q_CNT_W-1:0]   count_reg, count_next;

    function automatic logic [uvs_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [uvs_pkg::Q_PTR_W-1:0] p);
        begin
            if (p == uvs_pkg::Q_PTR_W'(uvs_pkg::Q_DEPTH - 1))
            begin
                ptr_inc = '0;
            end
            else
            begin
                ptr_inc = p + 1'b1;
            end
        end
    endfunction

    assign full       = (count_reg == uvs_pkg::Q_CNT_W'(uvs_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("job popped from an empty queue");

endmodule

### rtl/uvs_back.sv
// Back end: jobs to bytes and reports, one per cycle unless stalled.
module uvs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  uvs_pkg::job_t head_job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          out_byte_valid,
    output logic [7:0]    out_byte,
    output logic          out_last,
    output logic          out_text_done,
    output logic          out_text_valid,
    output logic [15:0]   out_total
);

    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    typedef enum logic [1:0] {
        PH_REPL,
        PH_PASS,
        PH_REPORT
    } phase_t;

    phase_t          phase;
    logic [2:0]      rcnt_reg, rcnt_next;
    logic [1:0]      sub_reg, sub_next;
    logic [2:0]      pidx_reg, pidx_next;
    logic            produce;
    logic            last;
    logic            r_bvalid, r_done, r_tvalid;
    logic [7:0]      r_byte;
    uvs_pkg::cnt_t   r_cnt;
    logic            valid_reg;
    logic            bvalid_reg;
    logic [7:0]      byte_reg;
    logic            last_reg;
    logic            done_reg;
    logic            tvalid_reg;
    logic [15:0]     total_reg;

    assign produce = head_valid && (!valid_reg || out_ready);
    assign pop     = produce && last;

    always_comb
    begin
        if (rcnt_reg < head_job.nrepl)
        begin
            phase = PH_REPL;
        end
        else if (pidx_reg < head_job.npass)
        begin
            phase = PH_PASS;
        end
        else
        begin
            phase = PH_REPORT;
        end
    end

    always_comb
    begin
        rcnt_next = rcnt_reg;
        sub_next  = sub_reg;
        pidx_next = pidx_reg;
        r_bvalid  = 1'b1;
        r_done    = 1'b0;
        r_tvalid  = 1'b0;
        r_byte    = 8'h00;
        r_cnt     = head_job.final_cnt;
        last      = 1'b0;
        case (phase)
            PH_REPL:
            begin
                case (sub_reg)
                    2'd0:    r_byte = REPL_B0;
                    2'd1:    r_byte = REPL_B1;
                    default: r_byte = REPL_B2;
                endcase
                r_cnt = uvs_pkg::sat_add(head_job.base_cnt, rcnt_reg + 3'd1);
                last  = (sub_reg == 2'd2) && (rcnt_reg + 3'd1 == head_job.nrepl) &&
                        (head_job.npass == 3'd0) && !head_job.report;
                if (sub_reg == 2'd2)
                begin
                    sub_next  = 2'd0;
                    rcnt_next = rcnt_reg + 3'd1;
                end
                else
                begin
                    sub_next = sub_reg + 2'd1;
                end
            end
            PH_PASS:
            begin
                r_byte    = head_job.bytes[pidx_reg[1:0]];
                last      = (pidx_reg + 3'd1 == head_job.npass) && !head_job.report;
                pidx_next = pidx_reg + 3'd1;
            end
            default:
            begin
                r_bvalid = 1'b0;
                r_done   = 1'b1;
                r_tvalid = head_job.text_valid;
                last     = 1'b1;
            end
        endcase
        if (last)
        begin
            rcnt_next = 3'd0;
            sub_next  = 2'd0;
            pidx_next = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcnt_reg   <= 3'd0;
            sub_reg    <= 2'd0;
            pidx_reg   <= 3'd0;
            valid_reg  <= 1'b0;
            bvalid_reg <= 1'b0;
            byte_reg   <= 8'h00;
            last_reg   <= 1'b0;
            done_reg   <= 1'b0;
            tvalid_reg <= 1'b0;
            total_reg  <= 16'h0000;
        end
        else
        begin
            if (produce)
            begin
                rcnt_reg   <= rcnt_next;
                sub_reg    <= sub_next;
                pidx_reg   <= pidx_next;
                valid_reg  <= 1'b1;
                bvalid_reg <= r_bvalid;
                byte_reg   <= r_byte;
                last_reg   <= last;
                done_reg   <= r_done;
                tvalid_reg <= r_tvalid;
                total_reg  <= 16'(r_cnt);
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte_valid = bvalid_reg;
    assign out_byte       = byte_reg;
    assign out_last       = last_reg;
    assign out_text_done  = done_reg;
    assign out_text_valid = tvalid_reg;
    assign out_total      = total_reg;

    a_report_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && done_reg) |-> last_reg)
        else $error("report result not marked last");

    a_pop_resets: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (rcnt_reg == 3'd0 && sub_reg == 2'd0 && pidx_reg == 3'd0))
        else $error("job counters not cleared after job end");

endmodule

### rtl/utf8_validate_sanitize_top.sv
// Top level of the streaming UTF-8 validator with U+FFFD replacement.
//
//  channel | dir | tdata                                           | tuser                  | tlast
//  s_*     | in  | [7:0] in_byte                                   | [0] cmd (1 = end text) | -
//  m_*     | out | [7:0] out_byte, [8] text_valid, [24:9] total    | [0] byte_valid,        | out_last
//          |     | [31:25] zero                                    | [1] text_done          |
//
//  One input byte per cycle when not stalled; a transaction yields 0 to 12 results, one per cycle.
//  Between accept and first result lie the job entry in the queue and the output register.
//  Input stalls only when the two-entry job queue is full, as replacements drain or output stalls.
//  Reset clears sequence state, counter and queue pointers at once; no clearing pass.
//  Output back-pressure holds the output register and back end; a full queue then stalls input.
module utf8_validate_sanitize_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [8] text_valid, [24:9] replace_total
    output logic [1:0]  m_tuser,   // [0] byte_valid, [1] text_done
    output logic        m_tlast
);

    logic          q_full;
    logic          q_push;
    uvs_pkg::job_t q_job;
    logic          q_pop;
    logic          q_head_valid;
    uvs_pkg::job_t q_head_job;

    logic          o_bvalid;
    logic [7:0]    o_byte;
    logic          o_done;
    logic          o_tvalid;
    logic [15:0]   o_total;

    uvs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_end   (s_tuser),
        .in_byte  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    uvs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    uvs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (q_head_valid),
        .head_job       (q_head_job),
        .pop            (q_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_byte_valid (o_bvalid),
        .out_byte       (o_byte),
        .out_last       (m_tlast),
        .out_text_done  (o_done),
        .out_text_valid (o_tvalid),
        .out_total      (o_total)
    );

    assign m_tdata = {7'b0, o_total, o_tvalid, o_byte};
    assign m_tuser = {o_done, o_bvalid};

endmodule
